FILE: rtl/core/slwbc_pkg.sv
package slwbc_pkg;

    // Sizes of the memory behind the line
    localparam int unsigned MEM_BYTES  = 65536;
    localparam int unsigned MEM_BLOCKS = MEM_BYTES / 8;
    localparam int unsigned IDX_W      = (MEM_BLOCKS > 1) ? $clog2(MEM_BLOCKS) : 1;

    // Field widths
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned TAG_W   = 13;
    localparam int unsigned OFS_W   = 3;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLOCK_W = 64;
    localparam int unsigned COST_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_IDX_W = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_READ  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WRITE = 8'd3;

    // Cost values after reset
    localparam logic [COST_W-1:0] RST_MEM_READ   = 16'd100;
    localparam logic [COST_W-1:0] RST_MEM_WRITE  = 16'd50;
    localparam logic [COST_W-1:0] RST_LINE_READ  = 16'd1;
    localparam logic [COST_W-1:0] RST_LINE_WRITE = 16'd1;

    // Access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Reciprocal for tag / MEM_BLOCKS; floor keeps the quotient at most one low
    localparam int unsigned SLOT_SHIFT = 26;
    localparam int unsigned QP_W       = TAG_W + SLOT_SHIFT;
    localparam logic [SLOT_SHIFT-1:0] SLOT_RECIP =
        SLOT_SHIFT'((64'd1 << SLOT_SHIFT) / MEM_BLOCKS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // zero one memory block of the sweep
        logic load;    // capture the request
        logic access;  // memory fetch and write back
        logic commit;  // update line, time and result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    // Approximate block quotient of a tag
    function automatic logic [TAG_W-1:0] slot_quot(input logic [TAG_W-1:0] tag);
        logic [QP_W-1:0] prod;
        prod = QP_W'(tag) * QP_W'(SLOT_RECIP);
        return prod[QP_W-1:SLOT_SHIFT];
    endfunction

endpackage

FILE: rtl/core/slwbc_ctrl.sv
module slwbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output slwbc_pkg::t_dp_cmd    o_cmd,
    input  slwbc_pkg::t_dp_status i_status
);
    import slwbc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequencing
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/slwbc_datapath.sv
module slwbc_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  slwbc_pkg::t_dp_cmd                 i_cmd,
    output slwbc_pkg::t_dp_status              o_status,
    input  logic                               i_cfg_we,
    input  logic [slwbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slwbc_pkg::COST_W-1:0]       i_cfg_data,
    input  logic                               i_action,
    input  logic [slwbc_pkg::ADDR_W-1:0]       i_byte_address,
    input  logic [slwbc_pkg::WORD_W-1:0]       i_write_word,
    output logic [slwbc_pkg::WORD_W-1:0]       o_read_word,
    output logic                               o_was_hit,
    output logic                               o_did_write_back,
    output logic [slwbc_pkg::TIME_W-1:0]       o_elapsed_time
);
    import slwbc_pkg::*;

    // Block memory
    logic [BLOCK_W-1:0] r_mem [MEM_BLOCKS];
    logic [BLOCK_W-1:0] r_mem_rdata;
    logic [IDX_W-1:0]   r_clear_idx;

    // Cost registers
    logic [COST_W-1:0] r_mem_read_cost, r_mem_write_cost;
    logic [COST_W-1:0] r_line_read_cost, r_line_write_cost;

    // Request
    logic               r_action;
    logic [ADDR_W-1:0]  r_addr;
    logic [WORD_W-1:0]  r_wdata;
    logic [TAG_W-1:0]   r_quot;
    logic [IDX_W-1:0]   r_new_slot;

    // Line
    logic [BLOCK_W-1:0] r_line_block;
    logic [TAG_W-1:0]   r_line_tag;
    logic [IDX_W-1:0]   r_line_slot;
    logic               r_line_valid, r_line_dirty;
    logic [TIME_W-1:0]  r_time;

    // Result
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_hit, r_out_wb;

    logic [TAG_W-1:0]   tag, qd, rem_raw, rem_fix;
    logic [IDX_W-1:0]   new_slot;
    logic               hit, write_back, upper;
    logic [BLOCK_W-1:0] base, n_block;
    logic [COST_W+1:0]  cost_sum;
    logic               n_dirty;

    // Block slot of the request tag: remainder with one correction step
    assign tag     = r_addr[ADDR_W-1:OFS_W];
    assign qd      = TAG_W'(32'(r_quot) * MEM_BLOCKS);
    assign rem_raw = tag - qd;
    assign rem_fix = (32'(rem_raw) >= MEM_BLOCKS) ? rem_raw - TAG_W'(MEM_BLOCKS) : rem_raw;
    assign new_slot = IDX_W'(rem_fix);

    assign hit        = r_line_valid && (r_line_tag == tag);
    assign write_back = !hit && r_line_valid && r_line_dirty;
    assign upper      = (r_addr[OFS_W-1:0] != '0);

    // New line contents
    always_comb begin
        base    = hit ? r_line_block : r_mem_rdata;
        n_block = base;
        if (r_action == ACT_WRITE) begin
            if (upper) begin
                n_block[BLOCK_W-1:WORD_W] = r_wdata;
            end else begin
                n_block[WORD_W-1:0] = r_wdata;
            end
        end
        n_dirty  = (r_action == ACT_WRITE) || (hit && r_line_dirty);
        cost_sum = (hit ? '0 : (COST_W+2)'(r_mem_read_cost))
                 + (write_back ? (COST_W+2)'(r_mem_write_cost) : '0)
                 + ((r_action == ACT_WRITE) ? (COST_W+2)'(r_line_write_cost)
                                            : (COST_W+2)'(r_line_read_cost));
    end

    // Memory: clearing sweep, fetch and write back (read sees old data)
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clear_idx] <= '0;
        end else if (i_cmd.access && write_back) begin
            r_mem[r_line_slot] <= r_line_block;
        end
        if (i_cmd.access && !hit) begin
            r_mem_rdata <= r_mem[new_slot];
        end
    end

    // Sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clear_idx <= r_clear_idx + 1'b1;
        end
    end

    assign o_status.clear_last = (r_clear_idx == IDX_W'(MEM_BLOCKS - 1));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_read_cost   <= RST_MEM_READ;
            r_mem_write_cost  <= RST_MEM_WRITE;
            r_line_read_cost  <= RST_LINE_READ;
            r_line_write_cost <= RST_LINE_WRITE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MEM_READ:   r_mem_read_cost   <= i_cfg_data;
                CFG_MEM_WRITE:  r_mem_write_cost  <= i_cfg_data;
                CFG_LINE_READ:  r_line_read_cost  <= i_cfg_data;
                CFG_LINE_WRITE: r_line_write_cost <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Request capture and slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_addr   <= i_byte_address;
            r_wdata  <= i_write_word;
            r_quot   <= slot_quot(i_byte_address[ADDR_W-1:OFS_W]);
        end
        if (i_cmd.access) begin
            r_new_slot <= new_slot;
        end
    end

    // Line state and time counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= 1'b0;
            r_line_dirty <= 1'b0;
            r_time       <= '0;
        end else if (i_cmd.commit) begin
            r_line_valid <= 1'b1;
            r_line_dirty <= n_dirty;
            r_time       <= r_time + TIME_W'(cost_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_line_block <= n_block;
            r_line_tag   <= tag;
            r_line_slot  <= hit ? r_line_slot : r_new_slot;
            r_out_word   <= upper ? n_block[BLOCK_W-1:WORD_W] : n_block[WORD_W-1:0];
            r_out_hit    <= hit;
            r_out_wb     <= write_back;
        end
    end

    assign o_read_word      = r_out_word;
    assign o_was_hit        = r_out_hit;
    assign o_did_write_back = r_out_wb;
    assign o_elapsed_time   = r_time;

endmodule

FILE: rtl/core/single_line_write_back_cache.sv
// One-line write-back cache in front of a block memory of MEM_BYTES bytes
// (8-byte blocks). Each request reads or writes one 32-bit word; offset 0 of
// a block picks the low word, any other offset the high word. A miss fetches
// the block and, when the old line is dirty, writes it back in the same
// cycle. Every result returns the selected word, hit and write-back flags and
// a wrapping 32-bit time counter built from the four programmable costs.
// After reset the block memory is zeroed by a sweep over all MEM_BYTES/8
// blocks before the first request is taken; cost registers may be written
// during the sweep. Each request then passes the capture, memory access and
// line update steps of the sequencer over the single block memory; the next
// request is taken only after the line update, which a held result register
// can stall. Write cost registers only while no request is in flight.
module single_line_write_back_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slwbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [slwbc_pkg::COST_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [slwbc_pkg::ADDR_W-1:0]    i_byte_address,
    input  logic [slwbc_pkg::WORD_W-1:0]    i_write_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [slwbc_pkg::WORD_W-1:0]    o_read_word,
    output logic                            o_was_hit,
    output logic                            o_did_write_back,
    output logic [slwbc_pkg::TIME_W-1:0]    o_elapsed_time
);
    import slwbc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    slwbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    slwbc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_byte_address   (i_byte_address),
        .i_write_word     (i_write_word),
        .o_read_word      (o_read_word),
        .o_was_hit        (o_was_hit),
        .o_did_write_back (o_did_write_back),
        .o_elapsed_time   (o_elapsed_time)
    );

endmodule
